FILE: design/npf_pkg.sv
// ----------------------------------------------------------------------------
// npf_pkg
// Word types, request codes and verdict codes of the ND prefix filter.
// ----------------------------------------------------------------------------
package npf_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        vlan_tagged;
        logic [11:0] vlan_id;
        logic [7:0]  next_header;
        logic [7:0]  icmp_type;
        logic        dst_multicast;
        logic        na_solicited;
        logic [15:0] capture_len;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
    } t_in_word;

    typedef struct packed {
        logic       report;
        logic       target_local;
        logic       is_solicitation;
        logic [3:0] verdict;
    } t_out_word;

    // request codes; any other code classifies a frame
    localparam logic [1:0] REQ_ADD_PFX  = 2'd0;
    localparam logic [1:0] REQ_ADD_VLAN = 2'd1;

    // verdict codes
    localparam logic [3:0] V_REPORT     = 4'd0;
    localparam logic [3:0] V_SHORT_HDR  = 4'd1;
    localparam logic [3:0] V_NOT_ICMP   = 4'd2;
    localparam logic [3:0] V_VLAN       = 4'd3;
    localparam logic [3:0] V_NOT_ND     = 4'd4;
    localparam logic [3:0] V_ND_SHORT   = 4'd5;
    localparam logic [3:0] V_UNICAST_NS = 4'd6;
    localparam logic [3:0] V_UNSOL_NA   = 4'd7;
    localparam logic [3:0] V_LOCAL      = 4'd8;
    localparam logic [3:0] V_ADDED      = 4'd9;
    localparam logic [3:0] V_FULL       = 4'd10;

    // configuration register indexes
    localparam logic CFG_REPORT_ALL = 1'b0;
    localparam logic CFG_ACCEPT_ANN = 1'b1;

    // protocol values
    localparam logic [7:0] ICMPV6_PROTO = 8'd58;
    localparam logic [7:0] ND_NS_TYPE   = 8'd135;
    localparam logic [7:0] ND_NA_TYPE   = 8'd136;
    localparam logic [7:0] PLEN_MAX     = 8'd128;

    // minimum capture lengths: Ethernet + optional tag + IPv6/ICMPv6 or ND message
    localparam logic [15:0] HDR_MIN     = 16'd62;
    localparam logic [15:0] HDR_MIN_TAG = 16'd66;
    localparam logic [15:0] ND_MIN      = 16'd78;
    localparam logic [15:0] ND_MIN_TAG  = 16'd82;

endpackage

FILE: design/npf_in_if.sv
// ----------------------------------------------------------------------------
// npf_in_if
// Valid/ready channel carrying request words into the ND prefix filter.
// ----------------------------------------------------------------------------
interface npf_in_if;
    logic              valid;
    logic              ready;
    npf_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/npf_out_if.sv
// ----------------------------------------------------------------------------
// npf_out_if
// Valid/ready channel carrying result words out of the ND prefix filter.
// ----------------------------------------------------------------------------
interface npf_out_if;
    logic               valid;
    logic               ready;
    npf_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ndp_packet_prefix_filter.sv
// Flow: a word is accepted in S_IDLE and evaluated in S_EVAL; add requests then go to S_DONE,
//   frames may first scan the VLAN table (S_VLAN) and then the prefix table (S_PFX).
// Handshake: one word at a time; ready returns once the last result has entered the
//   output register, which S_DONE delays while that register is full and the sink stalls.
//   Scan length is set by the single read port of each table memory, one entry a cycle.
// Reset (synchronous): clears counts, configuration and handshake state; tables are not cleared.
// ----------------------------------------------------------------------------
// ndp_packet_prefix_filter
// IPv6 Neighbor Discovery filter with a monitored VLAN list and a local prefix
// table, both kept in synchronous memories that are scanned per frame.
// ----------------------------------------------------------------------------
module ndp_packet_prefix_filter #(
    parameter int PREFIX_SLOTS = 16,
    parameter int VLAN_SLOTS   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    npf_in_if.sink    i_in,
    npf_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_addr,
    input  logic      i_cfg_wdata
);

    localparam int PCW = $clog2(PREFIX_SLOTS + 1);
    localparam int PIW = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
    localparam int VCW = $clog2(VLAN_SLOTS + 1);
    localparam int VIW = (VLAN_SLOTS > 1) ? $clog2(VLAN_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_VLAN = 5'b00100,
        S_PFX  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  len;
    } t_pfx_ent;

    function automatic logic [63:0] mask_hi(input logic [7:0] len);
        logic [63:0] m;
        if (len >= 8'd64) m = '1;
        else              m = ~({64{1'b1}} >> len[5:0]);
        return m;
    endfunction

    function automatic logic [63:0] mask_lo(input logic [7:0] len);
        logic [7:0]  rem;
        logic [63:0] m;
        rem = len - 8'd64;
        if (len <= 8'd64)       m = '0;
        else if (len >= 8'd128) m = '1;
        else                    m = ~({64{1'b1}} >> rem[5:0]);
        return m;
    endfunction

    // NS/NA type, ND length, multicast NS and solicited NA checks; V_REPORT means pass
    function automatic logic [3:0] post_chk(input npf_pkg::t_in_word it, input logic ann);
        logic        is_ns;
        logic        is_na;
        logic [15:0] lim;
        logic [3:0]  v;
        is_ns = (it.icmp_type == npf_pkg::ND_NS_TYPE);
        is_na = (it.icmp_type == npf_pkg::ND_NA_TYPE);
        lim   = it.vlan_tagged ? npf_pkg::ND_MIN_TAG : npf_pkg::ND_MIN;
        if (!is_ns && !is_na)                        v = npf_pkg::V_NOT_ND;
        else if (it.capture_len < lim)               v = npf_pkg::V_ND_SHORT;
        else if (is_ns && !it.dst_multicast)         v = npf_pkg::V_UNICAST_NS;
        else if (!is_ns && !it.na_solicited && !ann) v = npf_pkg::V_UNSOL_NA;
        else                                         v = npf_pkg::V_REPORT;
        return v;
    endfunction

    t_state             r_state, n_state;
    npf_pkg::t_in_word  r_item, n_item;
    npf_pkg::t_out_word r_res, n_res;
    npf_pkg::t_out_word r_out, n_out;
    logic               r_out_vld, n_out_vld;
    logic [PCW-1:0]     r_pcnt, n_pcnt;
    logic [VCW-1:0]     r_vcnt, n_vcnt;
    logic [PIW-1:0]     r_pidx, n_pidx;
    logic [VIW-1:0]     r_vidx, n_vidx;
    logic               r_more, n_more;
    logic               r_pend, n_pend;
    logic               r_last, n_last;
    logic               r_cfg_all;
    logic               r_cfg_ann;

    t_pfx_ent           pfx_mem [PREFIX_SLOTS];
    logic [11:0]        vlan_mem [VLAN_SLOTS];
    t_pfx_ent           r_pfx_q;
    logic [11:0]        r_vlan_q;

    logic               w_pfx_we;
    t_pfx_ent           w_pfx_wdata;
    logic               w_vlan_we;
    logic [7:0]         w_plen;
    logic [3:0]         w_post;
    logic [15:0]        w_hdr_lim;
    logic               w_pfx_hit;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign w_plen      = (r_item.prefix_len > npf_pkg::PLEN_MAX) ? npf_pkg::PLEN_MAX
                                                                  : r_item.prefix_len;
    assign w_pfx_wdata = '{hi:  r_item.addr_hi & mask_hi(w_plen),
                           lo:  r_item.addr_lo & mask_lo(w_plen),
                           len: w_plen};
    assign w_post      = post_chk(r_item, r_cfg_ann);
    assign w_hdr_lim   = r_item.vlan_tagged ? npf_pkg::HDR_MIN_TAG : npf_pkg::HDR_MIN;
    assign w_pfx_hit   = (((r_item.addr_hi ^ r_pfx_q.hi) & mask_hi(r_pfx_q.len)) == '0) &&
                         (((r_item.addr_lo ^ r_pfx_q.lo) & mask_lo(r_pfx_q.len)) == '0);

    // table memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_pfx_we) begin
            pfx_mem[r_pcnt[PIW-1:0]] <= w_pfx_wdata;
        end
        r_pfx_q <= pfx_mem[r_pidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_vlan_we) begin
            vlan_mem[r_vcnt[VIW-1:0]] <= r_item.vlan_id;
        end
        r_vlan_q <= vlan_mem[r_vidx];
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_pcnt    = r_pcnt;
        n_vcnt    = r_vcnt;
        n_pidx    = r_pidx;
        n_vidx    = r_vidx;
        n_more    = r_more;
        n_pend    = r_pend;
        n_last    = r_last;
        w_pfx_we  = 1'b0;
        w_vlan_we = 1'b0;

        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item  = i_in.data;
                    n_res   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                case (r_item.req_type)
                    npf_pkg::REQ_ADD_PFX: begin
                        if (r_pcnt == PCW'(PREFIX_SLOTS)) begin
                            n_res.verdict = npf_pkg::V_FULL;
                        end else begin
                            w_pfx_we      = 1'b1;
                            n_pcnt        = r_pcnt + PCW'(1);
                            n_res.verdict = npf_pkg::V_ADDED;
                        end
                    end
                    npf_pkg::REQ_ADD_VLAN: begin
                        if (r_vcnt == VCW'(VLAN_SLOTS)) begin
                            n_res.verdict = npf_pkg::V_FULL;
                        end else begin
                            w_vlan_we     = 1'b1;
                            n_vcnt        = r_vcnt + VCW'(1);
                            n_res.verdict = npf_pkg::V_ADDED;
                        end
                    end
                    default: begin
                        n_res.is_solicitation = (r_item.icmp_type == npf_pkg::ND_NS_TYPE);
                        if (r_item.capture_len < w_hdr_lim) begin
                            n_res.verdict = npf_pkg::V_SHORT_HDR;
                        end else if (r_item.next_header != npf_pkg::ICMPV6_PROTO) begin
                            n_res.verdict = npf_pkg::V_NOT_ICMP;
                        end else if (r_vcnt != '0) begin
                            if (!r_item.vlan_tagged) begin
                                n_res.verdict = npf_pkg::V_VLAN;
                            end else begin
                                n_vidx  = '0;
                                n_more  = 1'b1;
                                n_pend  = 1'b0;
                                n_state = S_VLAN;
                            end
                        end else if (w_post != npf_pkg::V_REPORT) begin
                            n_res.verdict = w_post;
                        end else if (r_pcnt != '0) begin
                            n_pidx  = '0;
                            n_more  = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_PFX;
                        end else begin
                            n_res.report  = 1'b1;
                            n_res.verdict = npf_pkg::V_REPORT;
                        end
                    end
                endcase
            end
            S_VLAN: begin
                // issue one read a cycle, compare the word read in the previous cycle
                n_pend = r_more;
                if (r_more) begin
                    n_last = (r_vidx == VIW'(r_vcnt - VCW'(1)));
                    if (n_last) n_more = 1'b0;
                    else        n_vidx = r_vidx + VIW'(1);
                end
                if (r_pend) begin
                    if (r_vlan_q == r_item.vlan_id) begin
                        if (w_post != npf_pkg::V_REPORT) begin
                            n_res.verdict = w_post;
                            n_state       = S_DONE;
                        end else if (r_pcnt != '0) begin
                            n_pidx  = '0;
                            n_more  = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_PFX;
                        end else begin
                            n_res.report  = 1'b1;
                            n_res.verdict = npf_pkg::V_REPORT;
                            n_state       = S_DONE;
                        end
                    end else if (r_last) begin
                        n_res.verdict = npf_pkg::V_VLAN;
                        n_state       = S_DONE;
                    end
                end
            end
            S_PFX: begin
                n_pend = r_more;
                if (r_more) begin
                    n_last = (r_pidx == PIW'(r_pcnt - PCW'(1)));
                    if (n_last) n_more = 1'b0;
                    else        n_pidx = r_pidx + PIW'(1);
                end
                if (r_pend && (w_pfx_hit || r_last)) begin
                    n_res.target_local = w_pfx_hit;
                    n_res.report       = !w_pfx_hit || r_cfg_all;
                    n_res.verdict      = n_res.report ? npf_pkg::V_REPORT : npf_pkg::V_LOCAL;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pcnt    <= '0;
            r_vcnt    <= '0;
            r_more    <= 1'b0;
            r_pend    <= 1'b0;
            r_last    <= 1'b0;
            r_pidx    <= '0;
            r_vidx    <= '0;
            r_cfg_all <= 1'b0;
            r_cfg_ann <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pcnt    <= n_pcnt;
            r_vcnt    <= n_vcnt;
            r_more    <= n_more;
            r_pend    <= n_pend;
            r_last    <= n_last;
            r_pidx    <= n_pidx;
            r_vidx    <= n_vidx;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    npf_pkg::CFG_REPORT_ALL: r_cfg_all <= i_cfg_wdata;
                    npf_pkg::CFG_ACCEPT_ANN: r_cfg_ann <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

FILE: design/npf_checker.sv
// ----------------------------------------------------------------------------
// npf_checker
// Port-level assertions for the ND prefix filter, bound to the top level.
// ----------------------------------------------------------------------------
module npf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input npf_pkg::t_out_word i_out_word
);

    // a result word waiting for the sink holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed while stalled");

    // one word in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready after accept");

    // report flag and report verdict agree
    a_report_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word.report == (i_out_word.verdict == npf_pkg::V_REPORT)))
        else $error("report flag and verdict disagree");

    // a prefix hit only ends in a report or local verdict
    a_local_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.target_local |->
            (i_out_word.verdict == npf_pkg::V_REPORT || i_out_word.verdict == npf_pkg::V_LOCAL))
        else $error("target_local with a wrong verdict");

    // table updates carry no frame flags
    a_add_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.verdict == npf_pkg::V_ADDED ||
                        i_out_word.verdict == npf_pkg::V_FULL) |->
            !i_out_word.report && !i_out_word.target_local && !i_out_word.is_solicitation)
        else $error("flags set on a table update result");

endmodule

bind ndp_packet_prefix_filter npf_checker u_npf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);

FILE: tb/ndp_packet_prefix_filter_tb.sv
// ----------------------------------------------------------------------------
// ndp_packet_prefix_filter_tb
// Drives prefix adds, VLAN adds and frame summaries into the ND filter with
// random gaps and stalls on both channels, predicts each verdict word from a
// local copy of the prefix and VLAN tables, and checks every result word.
// ----------------------------------------------------------------------------
module ndp_packet_prefix_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npf_pkg::*;

    localparam int PREFIX_DEPTH = 16;
    localparam int VLAN_DEPTH   = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 222;
    localparam int TAIL_CYCLES  = 64;

    localparam logic [1:0] REQ_CLASSIFY = 2'd2;
    localparam logic [1:0] REQ_RSVD     = 2'd3;

    localparam int ETH_BYTES      = 14;
    localparam int TAG_BYTES      = 4;
    localparam int IP6_ICMP_BYTES = 48;
    localparam int ND_BYTES       = 64;

    typedef enum int {
        DEF_SHORT_HDR, DEF_NOT_ICMP, DEF_VLAN, DEF_NOT_ND,
        DEF_ND_SHORT, DEF_UNICAST_NS, DEF_UNSOL_NA
    } t_defect;

    // ------------------------------------------------------------------------
    // verdict predictor and store of expected verdict words
    // ------------------------------------------------------------------------
    class nd_verdict_board;
        logic [127:0] pfx_addr [PREFIX_DEPTH];
        logic [7:0]   pfx_len  [PREFIX_DEPTH];
        int           pfx_count;
        logic [11:0]  vlan_ids [VLAN_DEPTH];
        int           vlan_count;
        bit           report_all;
        bit           accept_ann;
        t_out_word    pending_verdicts[$];
        int           mismatches;

        function logic [127:0] prefix_mask(logic [7:0] plen);
            return {128{1'b1}} << (PLEN_MAX - plen);
        endfunction

        function void set_config(logic idx, logic val);
            if (idx == CFG_REPORT_ALL) report_all = val;
            else accept_ann = val;
        endfunction

        function bit vlan_listed(logic [11:0] vid);
            for (int i = 0; i < vlan_count; i++)
                if (vlan_ids[i] == vid) return 1'b1;
            return 1'b0;
        endfunction

        function bit hits_local_prefix(logic [127:0] tgt);
            logic [127:0] m;
            for (int i = 0; i < pfx_count; i++) begin
                m = prefix_mask(pfx_len[i]);
                if ((tgt & m) == pfx_addr[i]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_out_word predict_verdict(t_in_word w);
            t_out_word r;
            logic [7:0] plen;
            int off;
            bit is_ns;
            r = '0;
            case (w.req_type)
                REQ_ADD_PFX: begin
                    plen = (w.prefix_len > PLEN_MAX) ? PLEN_MAX : w.prefix_len;
                    if (pfx_count >= PREFIX_DEPTH) begin
                        r.verdict = V_FULL;
                    end else begin
                        pfx_addr[pfx_count] = {w.addr_hi, w.addr_lo} & prefix_mask(plen);
                        pfx_len[pfx_count]  = plen;
                        pfx_count++;
                        r.verdict = V_ADDED;
                    end
                end
                REQ_ADD_VLAN: begin
                    if (vlan_count >= VLAN_DEPTH) begin
                        r.verdict = V_FULL;
                    end else begin
                        vlan_ids[vlan_count] = w.vlan_id;
                        vlan_count++;
                        r.verdict = V_ADDED;
                    end
                end
                default: begin
                    off   = ETH_BYTES + (w.vlan_tagged ? TAG_BYTES : 0);
                    is_ns = (w.icmp_type == ND_NS_TYPE);
                    r.is_solicitation = is_ns;
                    if (int'(w.capture_len) < off + IP6_ICMP_BYTES)
                        r.verdict = V_SHORT_HDR;
                    else if (w.next_header != ICMPV6_PROTO)
                        r.verdict = V_NOT_ICMP;
                    else if (vlan_count != 0 && !(w.vlan_tagged && vlan_listed(w.vlan_id)))
                        r.verdict = V_VLAN;
                    else if (w.icmp_type != ND_NS_TYPE && w.icmp_type != ND_NA_TYPE)
                        r.verdict = V_NOT_ND;
                    else if (int'(w.capture_len) < off + ND_BYTES)
                        r.verdict = V_ND_SHORT;
                    else if (is_ns && !w.dst_multicast)
                        r.verdict = V_UNICAST_NS;
                    else if (!is_ns && !w.na_solicited && !accept_ann)
                        r.verdict = V_UNSOL_NA;
                    else begin
                        r.target_local = hits_local_prefix({w.addr_hi, w.addr_lo});
                        if (!r.target_local || report_all) begin
                            r.report  = 1'b1;
                            r.verdict = V_REPORT;
                        end else begin
                            r.verdict = V_LOCAL;
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void note_request(t_in_word w);
            pending_verdicts.push_back(predict_verdict(w));
        endfunction

        function void check_verdict(t_out_word got);
            t_out_word exp_w;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result word with none expected: %p", $time, got);
                mismatches++;
                return;
            end
            exp_w = pending_verdicts.pop_front();
            if (got.report !== exp_w.report) begin
                $display("%0t: report expected %0d actual %0d", $time, exp_w.report, got.report);
                mismatches++;
            end
            if (got.target_local !== exp_w.target_local) begin
                $display("%0t: target_local expected %0d actual %0d",
                         $time, exp_w.target_local, got.target_local);
                mismatches++;
            end
            if (got.is_solicitation !== exp_w.is_solicitation) begin
                $display("%0t: is_solicitation expected %0d actual %0d",
                         $time, exp_w.is_solicitation, got.is_solicitation);
                mismatches++;
            end
            if (got.verdict !== exp_w.verdict) begin
                $display("%0t: verdict expected %0d actual %0d",
                         $time, exp_w.verdict, got.verdict);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_addr;
    logic i_cfg_wdata;

    npf_in_if  req_if ();
    npf_out_if res_if ();

    nd_verdict_board board = new();

    int src_idle_pct;
    int snk_idle_pct;
    int cycle_count;

    always #1 i_clk = ~i_clk;

    ndp_packet_prefix_filter #(
        .PREFIX_SLOTS (PREFIX_DEPTH),
        .VLAN_SLOTS   (VLAN_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, check on every accepted word
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_verdict(res_if.data);
    end

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------
    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_in_word mk_frame(bit vtag, logic [11:0] vid, logic [7:0] nh,
                                          logic [7:0] ity, bit mc, bit sol,
                                          logic [15:0] clen, logic [127:0] tgt);
        t_in_word w;
        w.req_type      = REQ_CLASSIFY;
        w.vlan_tagged   = vtag;
        w.vlan_id       = vid;
        w.next_header   = nh;
        w.icmp_type     = ity;
        w.dst_multicast = mc;
        w.na_solicited  = sol;
        w.capture_len   = clen;
        {w.addr_hi, w.addr_lo} = tgt;
        w.prefix_len    = $urandom;
        return w;
    endfunction

    function automatic t_in_word mk_add(logic [1:0] req, logic [11:0] vid,
                                        logic [127:0] addr, logic [7:0] plen);
        t_in_word w;
        w = mk_frame($urandom_range(1), vid, $urandom, $urandom, $urandom_range(1),
                     $urandom_range(1), $urandom, addr);
        w.req_type   = req;
        w.prefix_len = plen;
        return w;
    endfunction

    // target near a stored prefix: keep the prefix bits, sometimes flip one bit
    function automatic logic [127:0] near_target();
        int k;
        logic [127:0] m;
        logic [127:0] tgt;
        k   = $urandom_range(board.pfx_count - 1);
        m   = board.prefix_mask(board.pfx_len[k]);
        tgt = board.pfx_addr[k] | (rand_addr() & ~m);
        if ($urandom_range(9) < 3)
            tgt[$urandom_range(127)] ^= 1'b1;
        return tgt;
    endfunction

    function automatic t_in_word good_frame();
        t_in_word w;
        bit vtag;
        bit is_ns;
        logic [11:0] vid;
        int nd_min;
        logic [127:0] tgt;
        vtag   = (board.vlan_count > 0) ? 1'b1 : $urandom_range(1);
        vid    = (board.vlan_count > 0) ?
                 board.vlan_ids[$urandom_range(board.vlan_count - 1)] : $urandom;
        is_ns  = $urandom_range(1);
        nd_min = ETH_BYTES + (vtag ? TAG_BYTES : 0) + ND_BYTES;
        tgt    = (board.pfx_count > 0 && $urandom_range(9) < 6) ? near_target() : rand_addr();
        w = mk_frame(vtag, vid, ICMPV6_PROTO, is_ns ? ND_NS_TYPE : ND_NA_TYPE,
                     is_ns ? 1'b1 : $urandom_range(1),
                     is_ns ? $urandom_range(1) : ($urandom_range(3) != 0),
                     ($urandom_range(3) == 0) ? nd_min + $urandom_range(3)
                                              : $urandom_range(16'hffff, nd_min),
                     tgt);
        if ($urandom_range(7) == 0) w.req_type = REQ_RSVD;
        return w;
    endfunction

    function automatic t_in_word broken_frame();
        t_in_word w;
        int hdr_min;
        int nd_min;
        w = good_frame();
        hdr_min = ETH_BYTES + (w.vlan_tagged ? TAG_BYTES : 0) + IP6_ICMP_BYTES;
        nd_min  = hdr_min - IP6_ICMP_BYTES + ND_BYTES;
        case (t_defect'($urandom_range(DEF_UNSOL_NA, DEF_SHORT_HDR)))
            DEF_SHORT_HDR:
                w.capture_len = $urandom_range(1) ? hdr_min - 1 : $urandom_range(hdr_min - 1);
            DEF_NOT_ICMP: begin
                w.next_header = $urandom;
                if (w.next_header == ICMPV6_PROTO) w.next_header = ICMPV6_PROTO + 1;
            end
            DEF_VLAN: begin
                if ($urandom_range(1)) w.vlan_tagged = 1'b0;
                else w.vlan_id = $urandom;
            end
            DEF_NOT_ND: begin
                w.icmp_type = $urandom;
                if (w.icmp_type == ND_NS_TYPE || w.icmp_type == ND_NA_TYPE)
                    w.icmp_type = ND_NA_TYPE + 1;
            end
            DEF_ND_SHORT:
                w.capture_len = $urandom_range(nd_min - 1, hdr_min);
            DEF_UNICAST_NS: begin
                w.icmp_type     = ND_NS_TYPE;
                w.dst_multicast = 1'b0;
            end
            default: begin
                w.icmp_type    = ND_NA_TYPE;
                w.na_solicited = 1'b0;
            end
        endcase
        return w;
    endfunction

    function automatic t_in_word next_random_word(int phase);
        t_in_word w;
        int r;
        logic [7:0] plen;
        r = $urandom_range(99);
        if (r < 6) begin
            // hold the last prefix slot for a zero-length prefix late in the run
            if (board.pfx_count == PREFIX_DEPTH - 1 && phase < 4) return good_frame();
            if (board.pfx_count == PREFIX_DEPTH - 1) plen = '0;
            else if ($urandom_range(9) < 2) plen = $urandom_range(255, PLEN_MAX + 1);
            else plen = $urandom_range(PLEN_MAX, 1);
            return mk_add(REQ_ADD_PFX, $urandom, rand_addr(), plen);
        end
        if (r < 11) return mk_add(REQ_ADD_VLAN, $urandom, rand_addr(), $urandom);
        if (r < 19) begin
            w = mk_frame($urandom_range(1), $urandom, $urandom, $urandom, $urandom_range(1),
                         $urandom_range(1), $urandom, rand_addr());
            w.req_type = $urandom_range(REQ_RSVD, REQ_CLASSIFY);
            return w;
        end
        if (r < 28) return broken_frame();
        return good_frame();
    endfunction

    // ------------------------------------------------------------------------
    // drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        board.note_request(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_filter_mode(bit all_nets, bit accept_unsol);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_REPORT_ALL;
        i_cfg_wdata <= all_nets;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_ACCEPT_ANN;
        i_cfg_wdata <= accept_unsol;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_config(CFG_REPORT_ALL, all_nets);
        board.set_config(CFG_ACCEPT_ANN, accept_unsol);
    endtask

    task automatic run_directed();
        logic [127:0] ones;
        logic [127:0] pfx_a;
        t_in_word w;
        ones  = {128{1'b1}};
        pfx_a = rand_addr();
        // empty tables: each check stage but the VLAN check, in order
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 1, 0, ND_MIN, rand_addr()));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 1, 0, HDR_MIN - 1, ones));
        send_word(mk_frame(1, 4095, ICMPV6_PROTO, ND_NA_TYPE, 1, 1, HDR_MIN_TAG - 1, '0));
        send_word(mk_frame(0, 0, '0, ND_NS_TYPE, 1, 1, HDR_MIN, rand_addr()));
        send_word(mk_frame(1, 1, 8'hff, ND_NS_TYPE, 1, 1, HDR_MIN_TAG, rand_addr()));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, '0, 1, 1, HDR_MIN, rand_addr()));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, 8'hff, 1, 1, 16'hffff, rand_addr()));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 1, 1, ND_MIN - 1, rand_addr()));
        send_word(mk_frame(1, 9, ICMPV6_PROTO, ND_NA_TYPE, 1, 1, ND_MIN_TAG - 1, rand_addr()));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 0, 1, ND_MIN, rand_addr()));
        send_word(mk_frame(1, 3, ICMPV6_PROTO, ND_NA_TYPE, 0, 0, ND_MIN_TAG, rand_addr()));
        w = mk_frame(1, 4095, ICMPV6_PROTO, ND_NA_TYPE, 1, 1, 16'hffff, rand_addr());
        w.req_type = REQ_RSVD;
        send_word(w);
        // prefixes: over-long length saturates, then a /64
        send_word(mk_add(REQ_ADD_PFX, 0, ones, 8'hff));
        send_word(mk_add(REQ_ADD_PFX, 4095, pfx_a, 8'd64));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 1, 0, ND_MIN, ones));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NA_TYPE, 1, 1, ND_MIN,
                           {pfx_a[127:64], $urandom, $urandom}));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NA_TYPE, 1, 1, ND_MIN,
                           {~pfx_a[127:64], $urandom, $urandom}));
        // VLAN list: untagged frames fail once any VLAN is listed
        send_word(mk_add(REQ_ADD_VLAN, '0, rand_addr(), $urandom));
        send_word(mk_add(REQ_ADD_VLAN, 12'hfff, rand_addr(), $urandom));
        send_word(mk_frame(0, 0, ICMPV6_PROTO, ND_NS_TYPE, 1, 1, ND_MIN, rand_addr()));
        send_word(mk_frame(1, 12'hfff, ICMPV6_PROTO, ND_NS_TYPE, 1, 1, ND_MIN_TAG, ones));
        send_word(mk_frame(1, '0, ICMPV6_PROTO, ND_NA_TYPE, 0, 1, ND_MIN_TAG, rand_addr()));
        send_word(mk_frame(1, 12'd7, ICMPV6_PROTO, ND_NS_TYPE, 1, 1, ND_MIN_TAG, rand_addr()));
        drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit all_nets_seq [PHASES]     = '{1, 0, 1, 0, 1, 0};
        bit accept_unsol_seq [PHASES] = '{1, 1, 0, 0, 1, 1};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = 1'b0;
        i_cfg_wdata  = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        cycle_count  = 0;
        src_idle_pct = 23;
        snk_idle_pct = 83;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            // two phases per idle pattern: sender light, then receiver light, then none
            case (p / 2)
                0: begin src_idle_pct = 23; snk_idle_pct = 83; end
                1: begin src_idle_pct = 83; snk_idle_pct = 23; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            set_filter_mode(all_nets_seq[p], accept_unsol_seq[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(next_random_word(p));
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
